### src/pht_pkg.sv
// Shared types and constants for the heading turn controller.
package pht_pkg;

	localparam int ADDR_W = 5;

	localparam logic [2:0] REG_TARGET  = 3'd0;
	localparam logic [2:0] REG_GAIN_P  = 3'd1;
	localparam logic [2:0] REG_GAIN_I  = 3'd2;
	localparam logic [2:0] REG_GAIN_D  = 3'd3;
	localparam logic [2:0] REG_PWR_MAX = 3'd4;
	localparam logic [2:0] REG_PWR_MIN = 3'd5;
	localparam logic [2:0] REG_TICK_LIM = 3'd6;
	localparam logic [2:0] REG_SETTLE  = 3'd7;

	localparam logic [1:0] ST_RUN     = 2'd0;
	localparam logic [1:0] ST_SETTLED = 2'd1;
	localparam logic [1:0] ST_TIMEOUT = 2'd2;
	localparam logic [1:0] ST_IDLE    = 2'd3;

	localparam logic signed [21:0] RST_TARGET   = 22'sd0;
	localparam logic signed [23:0] RST_GAIN_P   = 24'sd117965;
	localparam logic signed [23:0] RST_GAIN_I   = -24'sd92;
	localparam logic signed [23:0] RST_GAIN_D   = 24'sd6554;
	localparam logic [6:0]         RST_PWR_MAX  = 7'd70;
	localparam logic [6:0]         RST_PWR_MIN  = 7'd1;
	localparam logic [15:0]        RST_TICK_LIM = 16'd300;
	localparam logic [19:0]        RST_SETTLE   = 20'd256;

	localparam logic [2:0]         HOLD_SAT  = 3'd7;
	localparam logic [15:0]        TICK_SAT  = 16'hFFFF;
	localparam logic signed [39:0] INTEG_MAX = {1'b0, {39{1'b1}}};
	localparam logic signed [39:0] INTEG_MIN = {1'b1, {39{1'b0}}};

	typedef struct packed {
		logic signed [21:0] target_angle;
		logic signed [23:0] gain_p;
		logic signed [23:0] gain_i;
		logic signed [23:0] gain_d;
		logic [6:0]         power_max;
		logic [6:0]         power_min;
		logic [15:0]        tick_limit;
		logic [19:0]        settle_band;
	} cfg_t;

	typedef struct packed {
		logic signed [22:0] err;
		logic signed [39:0] integ;
		logic signed [23:0] deriv;
		logic [1:0]         status;
		logic               zero;
	} trk_t;

	typedef struct packed {
		logic signed [63:0] sum;
		logic [1:0]         status;
		logic               zero;
	} mac_t;

endpackage

### src/pht_cfg.sv
// Configuration register file behind the APB-style port.
module pht_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [pht_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output pht_pkg::cfg_t              cfg
);

	logic [2:0] idx;
	logic       wr;
	pht_pkg::cfg_t cfg_q;

	assign idx    = paddr[pht_pkg::ADDR_W-1:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_angle <= pht_pkg::RST_TARGET;
			cfg_q.gain_p       <= pht_pkg::RST_GAIN_P;
			cfg_q.gain_i       <= pht_pkg::RST_GAIN_I;
			cfg_q.gain_d       <= pht_pkg::RST_GAIN_D;
			cfg_q.power_max    <= pht_pkg::RST_PWR_MAX;
			cfg_q.power_min    <= pht_pkg::RST_PWR_MIN;
			cfg_q.tick_limit   <= pht_pkg::RST_TICK_LIM;
			cfg_q.settle_band  <= pht_pkg::RST_SETTLE;
		end else if (wr) begin
			unique case (idx)
				pht_pkg::REG_TARGET:   cfg_q.target_angle <= pwdata[21:0];
				pht_pkg::REG_GAIN_P:   cfg_q.gain_p       <= pwdata[23:0];
				pht_pkg::REG_GAIN_I:   cfg_q.gain_i       <= pwdata[23:0];
				pht_pkg::REG_GAIN_D:   cfg_q.gain_d       <= pwdata[23:0];
				pht_pkg::REG_PWR_MAX:  cfg_q.power_max    <= pwdata[6:0];
				pht_pkg::REG_PWR_MIN:  cfg_q.power_min    <= pwdata[6:0];
				pht_pkg::REG_TICK_LIM: cfg_q.tick_limit   <= pwdata[15:0];
				pht_pkg::REG_SETTLE:   cfg_q.settle_band  <= pwdata[19:0];
				default: ;
			endcase
		end
	end

	// Signed registers read back sign extended.
	always_comb begin
		unique case (idx)
			pht_pkg::REG_TARGET:   prdata = {{10{cfg_q.target_angle[21]}}, cfg_q.target_angle};
			pht_pkg::REG_GAIN_P:   prdata = {{8{cfg_q.gain_p[23]}}, cfg_q.gain_p};
			pht_pkg::REG_GAIN_I:   prdata = {{8{cfg_q.gain_i[23]}}, cfg_q.gain_i};
			pht_pkg::REG_GAIN_D:   prdata = {{8{cfg_q.gain_d[23]}}, cfg_q.gain_d};
			pht_pkg::REG_PWR_MAX:  prdata = {25'd0, cfg_q.power_max};
			pht_pkg::REG_PWR_MIN:  prdata = {25'd0, cfg_q.power_min};
			pht_pkg::REG_TICK_LIM: prdata = {16'd0, cfg_q.tick_limit};
			pht_pkg::REG_SETTLE:   prdata = {12'd0, cfg_q.settle_band};
			default:               prdata = 32'd0;
		endcase
	end

endmodule

### src/pht_track.sv
// Error, integral, derivative and turn state update, one tick per cycle while adv is high.
module pht_track #(
	parameter int unsigned HOLD_TICKS = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               start_s1,
	input  logic signed [21:0] meas_s1,
	input  pht_pkg::cfg_t      cfg,
	output pht_pkg::trk_t      rec_s2
);

	localparam logic [2:0] HOLD_LIM = 3'(HOLD_TICKS);

	logic signed [39:0] integ_q;
	logic signed [22:0] prev_q;
	logic [2:0]         hold_q;
	logic [15:0]        tick_q;
	logic               running_q;

	logic               run_c;
	logic signed [39:0] integ_c;
	logic signed [22:0] prev_c;
	logic [2:0]         hold_c;
	logic [15:0]        tick_c;
	logic               early_to;
	logic signed [22:0] err_c;
	logic [40:0]        isum;
	logic signed [39:0] integ_n;
	logic signed [23:0] deriv_c;
	logic [22:0]        err_neg;
	logic [21:0]        abs_err;
	logic [2:0]         hold_z;
	logic [2:0]         hold_n;
	logic [15:0]        tick_n;
	logic               settled;
	logic               late_to;

	// A start clears the turn state before this tick is evaluated.
	assign run_c    = start_s1 || running_q;
	assign integ_c  = start_s1 ? '0 : integ_q;
	assign prev_c   = start_s1 ? '0 : prev_q;
	assign hold_c   = start_s1 ? '0 : hold_q;
	assign tick_c   = start_s1 ? '0 : tick_q;
	assign early_to = tick_c >= cfg.tick_limit;

	assign err_c = {cfg.target_angle[21], cfg.target_angle} - {meas_s1[21], meas_s1};

	// Saturate the integral when the top two bits of the sum disagree.
	assign isum = {integ_c[39], integ_c} + {{18{err_c[22]}}, err_c};
	always_comb begin
		if (err_c == '0)
			integ_n = '0;
		else if (isum[40] != isum[39])
			integ_n = isum[40] ? pht_pkg::INTEG_MIN : pht_pkg::INTEG_MAX;
		else
			integ_n = isum[39:0];
	end

	assign deriv_c = {err_c[22], err_c} - {prev_c[22], prev_c};

	assign err_neg = -err_c;
	assign abs_err = err_c[22] ? err_neg[21:0] : err_c[21:0];
	assign hold_z  = (abs_err > {2'b00, cfg.settle_band}) ? 3'd0 : hold_c;
	assign settled = hold_z > HOLD_LIM;
	assign hold_n  = (hold_z < pht_pkg::HOLD_SAT) ? hold_z + 3'd1 : hold_z;
	assign tick_n  = (tick_c != pht_pkg::TICK_SAT) ? tick_c + 16'd1 : tick_c;
	assign late_to = tick_n >= cfg.tick_limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q   <= '0;
			prev_q    <= '0;
			hold_q    <= '0;
			tick_q    <= '0;
			running_q <= 1'b0;
		end else if (adv) begin
			if (!run_c || early_to) begin
				integ_q   <= integ_c;
				prev_q    <= prev_c;
				hold_q    <= hold_c;
				tick_q    <= tick_c;
				running_q <= 1'b0;
			end else begin
				integ_q   <= integ_n;
				prev_q    <= err_c;
				hold_q    <= hold_n;
				tick_q    <= tick_n;
				running_q <= !(settled || late_to);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rec_s2.err   <= err_c;
			rec_s2.integ <= integ_n;
			rec_s2.deriv <= deriv_c;
			if (!run_c) begin
				rec_s2.status <= pht_pkg::ST_IDLE;
				rec_s2.zero   <= 1'b1;
			end else if (early_to) begin
				rec_s2.status <= pht_pkg::ST_TIMEOUT;
				rec_s2.zero   <= 1'b1;
			end else begin
				rec_s2.zero <= 1'b0;
				if (settled)
					rec_s2.status <= pht_pkg::ST_SETTLED;
				else if (late_to)
					rec_s2.status <= pht_pkg::ST_TIMEOUT;
				else
					rec_s2.status <= pht_pkg::ST_RUN;
			end
		end
	end

endmodule

### src/pht_mac.sv
// PID products in one stage, their sum in the next.
module pht_mac (
	input  logic          clk,
	input  logic          adv_s3,
	input  logic          adv_s4,
	input  pht_pkg::trk_t rec_s2,
	input  pht_pkg::cfg_t cfg,
	output pht_pkg::mac_t rec_s4
);

	logic signed [46:0] prod_p_s3;
	logic signed [63:0] prod_i_s3;
	logic signed [47:0] prod_d_s3;
	logic [1:0]         status_s3;
	logic               zero_s3;

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			prod_p_s3 <= $signed(rec_s2.err) * $signed(cfg.gain_p);
			prod_i_s3 <= $signed(rec_s2.integ) * $signed(cfg.gain_i);
			prod_d_s3 <= $signed(rec_s2.deriv) * $signed(cfg.gain_d);
			status_s3 <= rec_s2.status;
			zero_s3   <= rec_s2.zero;
		end
	end

	// Q.24 percent; the integral term dominates and stays inside 64 bits.
	always_ff @(posedge clk) begin
		if (adv_s4) begin
			rec_s4.sum <= {{17{prod_p_s3[46]}}, prod_p_s3} + prod_i_s3
				+ {{16{prod_d_s3[47]}}, prod_d_s3};
			rec_s4.status <= status_s3;
			rec_s4.zero   <= zero_s3;
		end
	end

endmodule

### src/pht_drive.sv
// Drive clamp and truncation into the result register.
module pht_drive (
	input  logic          clk,
	input  logic          load,
	input  pht_pkg::mac_t rec_s4,
	input  logic [6:0]    power_max,
	input  logic [6:0]    power_min,
	output logic [7:0]    left_q,
	output logic [7:0]    right_q,
	output logic [1:0]    status_q
);

	logic        neg;
	logic [63:0] sum_neg;
	logic [63:0] mag_raw;
	logic [63:0] min_q24;
	logic [63:0] max_q24;
	logic [63:0] mag_lo;
	logic [63:0] mag_cl;
	logic [7:0]  mag;
	logic [7:0]  power;

	assign neg     = rec_s4.sum[63];
	assign sum_neg = -rec_s4.sum;
	assign mag_raw = neg ? sum_neg : rec_s4.sum;
	assign min_q24 = {33'd0, power_min, 24'd0};
	assign max_q24 = {33'd0, power_max, 24'd0};

	// Raise a nonzero magnitude to the floor, then clip; the clip wins.
	assign mag_lo = (mag_raw != '0 && mag_raw < min_q24) ? min_q24 : mag_raw;
	assign mag_cl = (mag_lo > max_q24) ? max_q24 : mag_lo;
	assign mag    = {1'b0, mag_cl[30:24]};

	always_comb begin
		if (rec_s4.zero)
			power = 8'd0;
		else if (neg)
			power = -mag;
		else
			power = mag;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			left_q   <= power;
			right_q  <= -power;
			status_q <= rec_s4.status;
		end
	end

endmodule

### src/pid_heading_turn_with_settle.sv
// Top level of the PID heading turn controller.
//
// One input transaction is one control tick: a gyro heading in Q.8 degrees and a start bit
// that begins a new turn. The controller forms error = target - heading, a saturating 40-bit
// integral (cleared on exactly zero error) and the derivative, sums the PID terms in Q.24
// percent, clamps the magnitude between power_min and power_max and truncates to whole
// percent. left_power carries the drive, right_power its negation, and status reports
// running, settled this tick, timed out, or idle (drive zero). One transaction can enter every
// cycle while result_ready lets results drain: the turn state (integral, previous error, hold
// and tick counters) closes its loop in the first stage, the three gain multiplies and the sum
// follow in registered stages, and the clamp feeds the result register. Each stage moves on
// whenever the one after it is free, so the input side keeps taking ticks while a result
// waits, until every stage is occupied.
// Gains and limits sit in an APB-style register file, byte address 4*index; write them only
// while no tick is in flight.
module pid_heading_turn_with_settle #(
	parameter int unsigned HOLD_TICKS = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,

	input  logic                       item_valid,
	output logic                       item_ready,
	input  logic                       start_req,
	input  logic signed [21:0]         measured_angle,

	output logic                       result_valid,
	input  logic                       result_ready,
	output logic signed [7:0]          left_power,
	output logic signed [7:0]          right_power,
	output logic [1:0]                 status,

	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [pht_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	pht_pkg::cfg_t cfg;
	pht_pkg::trk_t rec_s2;
	pht_pkg::mac_t rec_s4;

	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_q;
	logic               start_s1;
	logic signed [21:0] meas_s1;
	logic               accept;
	logic               free_q, free_s4, free_s3, free_s2, free_s1;
	logic               take_s1, take_s2, take_s3, take_s4;
	logic [7:0]         left_q, right_q;
	logic [1:0]         status_q;

	pht_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Handshake chain: a stage is free when empty or when its item moves on this cycle.
	assign free_q  = !vld_q || result_ready;
	assign take_s4 = vld_s4 && free_q;
	assign free_s4 = !vld_s4 || free_q;
	assign take_s3 = vld_s3 && free_s4;
	assign free_s3 = !vld_s3 || free_s4;
	assign take_s2 = vld_s2 && free_s3;
	assign free_s2 = !vld_s2 || free_s3;
	assign take_s1 = vld_s1 && free_s2;
	assign free_s1 = !vld_s1 || free_s2;

	assign item_ready = free_s1;
	assign accept     = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_q  <= 1'b0;
		end else begin
			if (accept)
				vld_s1 <= 1'b1;
			else if (take_s1)
				vld_s1 <= 1'b0;
			if (take_s1)
				vld_s2 <= 1'b1;
			else if (take_s2)
				vld_s2 <= 1'b0;
			if (take_s2)
				vld_s3 <= 1'b1;
			else if (take_s3)
				vld_s3 <= 1'b0;
			if (take_s3)
				vld_s4 <= 1'b1;
			else if (take_s4)
				vld_s4 <= 1'b0;
			if (take_s4)
				vld_q <= 1'b1;
			else if (result_ready)
				vld_q <= 1'b0;
		end
	end

	// Input register: hold the tick until the state stage takes it.
	always_ff @(posedge clk) begin
		if (accept) begin
			start_s1 <= start_req;
			meas_s1  <= measured_angle;
		end
	end

	pht_track #(
		.HOLD_TICKS (HOLD_TICKS)
	) u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (take_s1),
		.start_s1 (start_s1),
		.meas_s1  (meas_s1),
		.cfg      (cfg),
		.rec_s2   (rec_s2)
	);

	pht_mac u_mac (
		.clk    (clk),
		.adv_s3 (take_s2),
		.adv_s4 (take_s3),
		.rec_s2 (rec_s2),
		.cfg    (cfg),
		.rec_s4 (rec_s4)
	);

	pht_drive u_drive (
		.clk       (clk),
		.load      (take_s4),
		.rec_s4    (rec_s4),
		.power_max (cfg.power_max),
		.power_min (cfg.power_min),
		.left_q    (left_q),
		.right_q   (right_q),
		.status_q  (status_q)
	);

	assign result_valid = vld_q;
	assign left_power   = left_q;
	assign right_power  = right_q;
	assign status       = status_q;

	// An idle tick drives nothing.
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == pht_pkg::ST_IDLE |-> left_power == 8'sd0 && right_power == 8'sd0)
		else $error("idle result with nonzero drive");

	// The two sides always cancel.
	a_sides_cancel: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> 8'(left_power + right_power) == 8'd0)
		else $error("right drive is not the negation of left drive");

	// Occupancy grows by one when a tick enters and none leaves.
	a_occ_up: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !(result_valid && result_ready) |=>
		$countones({vld_s1, vld_s2, vld_s3, vld_s4, vld_q})
			== $past($countones({vld_s1, vld_s2, vld_s3, vld_s4, vld_q})) + 1)
		else $error("tick lost or duplicated on entry");

	// Occupancy shrinks by one when a result leaves and none enters.
	a_occ_down: assert property (@(posedge clk) disable iff (!arst_n)
		!accept && result_valid && result_ready |=>
		$countones({vld_s1, vld_s2, vld_s3, vld_s4, vld_q})
			== $past($countones({vld_s1, vld_s2, vld_s3, vld_s4, vld_q})) - 1)
		else $error("result lost or duplicated on exit");

endmodule
